>>> rtl/stuffed_crc8_frame_decoder_macros.svh
// Assertion macros for the stuffed CRC-8 frame decoder checker.
// No dependencies.
`ifndef STUFFED_CRC8_FRAME_DECODER_MACROS_SVH
`define STUFFED_CRC8_FRAME_DECODER_MACROS_SVH

// antecedent holds in a cycle -> consequent holds in that same cycle
`define SCFD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scfd check failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define SCFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scfd check failed");

// checked through reset as well
`define SCFD_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("scfd reset check failed");

`endif

>>> rtl/scfd_pkg.sv
// Shared types, codes and CRC-8 step function for the stuffed CRC-8 frame decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scfd_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7e;
   localparam logic [7:0] ESC_BYTE  = 8'h7d;

   localparam int STORE_DEPTH = 8;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_BADLEN  = 3'd3;
   localparam logic [2:0] ST_BADCRC  = 3'd4;

   localparam logic [1:0] CSR_POLY = 2'd0;
   localparam logic [1:0] CSR_INIT = 2'd1;

   localparam logic [7:0] POLY_RESET = 8'h07;
   localparam logic [7:0] INIT_RESET = 8'h00;

   typedef logic [7:0] byte_type;
   typedef byte_type [STORE_DEPTH-1:0] store_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  msg_type;
      logic [55:0] payload;
      logic [2:0]  payload_len;
   } result_type;

   // full frame length (type, payload, crc) for known types 0 to 4
   function automatic logic [5:0] frame_len(input logic [2:0] msg_type);
      logic [5:0] len;
      begin
         unique case (msg_type)
            3'd0: len = 6'd9;
            3'd1: len = 6'd7;
            default: len = 6'd3;
         endcase
         return len;
      end
   endfunction

   // MSB-first, non-reflected CRC-8 over one byte
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
      logic [7:0] c;
      begin
         c = crc ^ data;
         for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
         end
         return c;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/scfd_classify.sv
// Frame close classification: status, type and payload from the stored frame.
// Depends on scfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scfd_classify (
   input  wire scfd_pkg::store_type  store,
   input  wire logic [5:0]           byte_count,
   input  wire logic [7:0]           crc_before_last,
   input  wire logic [7:0]           last_byte,
   output scfd_pkg::result_type      result
);

   logic [2:0] plen;

   assign plen = 3'(byte_count - 6'd2);

   always_comb begin
      result = '0;
      priority if (byte_count == 6'd0) begin
         result.status = scfd_pkg::ST_EMPTY;
      end else if (store[0] >= 8'd5) begin
         result.status   = scfd_pkg::ST_UNKNOWN;
         result.msg_type = store[0];
      end else if (byte_count != scfd_pkg::frame_len(store[0][2:0])) begin
         result.status   = scfd_pkg::ST_BADLEN;
         result.msg_type = store[0];
      end else if (crc_before_last != last_byte) begin
         result.status   = scfd_pkg::ST_BADCRC;
         result.msg_type = store[0];
      end else begin
         result.status      = scfd_pkg::ST_OK;
         result.msg_type    = store[0];
         result.payload_len = plen;
         for (int i = 0; i < scfd_pkg::STORE_DEPTH - 1; i++) begin
            if (3'(i) < plen) begin
               result.payload[8*i +: 8] = store[i+1];
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/stuffed_crc8_frame_decoder.sv
// Byte-stuffed frame decoder with CRC-8 check, top level.
// Depends on scfd_pkg and scfd_classify.
//
// Usage:
//   req_valid/req_stall/req_rx_byte carry raw received bytes, one per
//   transaction. 0x7e opens and closes a frame, 0x7d makes the next byte
//   literal. Each close gives one transaction on rsp_valid/rsp_stall with
//   status, message type, payload and payload length; other bytes give none.
//   csr_valid/csr_ready/csr_index/csr_wdata write the polynomial (index 0)
//   and the initial CRC value (index 1); csr_ready is always high.
// Timing:
//   A byte is decoded while it sits in the input register, and a closing
//   byte loads its result into the result register, which drives rsp_valid.
//   One byte per cycle is taken while the result register drains.
//   When the receiver stalls with a result waiting, the input register holds
//   its byte and req_stall rises until the result is taken.
// Reset:
//   Synchronous, active high. Clears both registers' valid flags, leaves the
//   block outside a frame and restores polynomial 0x07 and initial value 0x00.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_crc8_frame_decoder #(
   parameter int MAX_FRAME = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_msg_type,
   output logic [55:0]      rsp_payload,
   output logic [2:0]       rsp_payload_len,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam logic [5:0] MaxCount = 6'(MAX_FRAME);

   logic [7:0] poly_ff, poly_in;
   logic [7:0] init_ff, init_in;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   logic       in_frame_ff, in_frame_in;
   logic       esc_ff, esc_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] crc_run_ff, crc_run_in;
   logic [7:0] crc_before_ff, crc_before_in;
   logic [7:0] last_ff, last_in;
   scfd_pkg::store_type store_ff, store_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   scfd_pkg::result_type rsp_ff, rsp_in;
   scfd_pkg::result_type close_result;

   logic advance;
   logic accept;
   logic take;
   logic close;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      poly_in = poly_ff;
      init_in = init_ff;
      if (csr_valid) begin
         if (csr_index == scfd_pkg::CSR_POLY) begin
            poly_in = csr_wdata;
         end else if (csr_index == scfd_pkg::CSR_INIT) begin
            init_in = csr_wdata;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // decode of the byte in the input register
   always_comb begin
      take  = 1'b0;
      close = 1'b0;
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      count_in      = count_ff;
      crc_run_in    = crc_run_ff;
      crc_before_in = crc_before_ff;
      last_in       = last_ff;
      store_in      = store_ff;
      if (advance) begin
         priority if (!in_frame_ff) begin
            if (in_byte_ff == scfd_pkg::FLAG_BYTE) begin
               in_frame_in   = 1'b1;
               esc_in        = 1'b0;
               count_in      = '0;
               crc_run_in    = init_ff;
               crc_before_in = init_ff;
            end
         end else if (esc_ff) begin
            esc_in = 1'b0;
            take   = 1'b1;
         end else if (in_byte_ff == scfd_pkg::ESC_BYTE) begin
            esc_in = 1'b1;
         end else if (in_byte_ff == scfd_pkg::FLAG_BYTE) begin
            close       = 1'b1;
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            take = 1'b1;
         end
         if (take) begin
            crc_before_in = crc_run_ff;
            crc_run_in    = scfd_pkg::crc8_step(crc_run_ff, in_byte_ff, poly_ff);
            last_in       = in_byte_ff;
            if (count_ff < 6'(scfd_pkg::STORE_DEPTH)) begin
               store_in[count_ff[2:0]] = in_byte_ff;
            end
            if (count_ff < MaxCount) begin
               count_in = count_ff + 6'd1;
            end
         end
      end
   end

   scfd_classify u_classify (
      .store           (store_ff),
      .byte_count      (count_ff),
      .crc_before_last (crc_before_ff),
      .last_byte       (last_ff),
      .result          (close_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (close) begin
         rsp_valid_in = 1'b1;
         rsp_in       = close_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff       <= scfd_pkg::POLY_RESET;
         init_ff       <= scfd_pkg::INIT_RESET;
         in_valid_ff   <= 1'b0;
         in_frame_ff   <= 1'b0;
         esc_ff        <= 1'b0;
         count_ff      <= '0;
         crc_run_ff    <= scfd_pkg::INIT_RESET;
         crc_before_ff <= scfd_pkg::INIT_RESET;
         last_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poly_ff       <= poly_in;
         init_ff       <= init_in;
         in_valid_ff   <= in_valid_in;
         in_frame_ff   <= in_frame_in;
         esc_ff        <= esc_in;
         count_ff      <= count_in;
         crc_run_ff    <= crc_run_in;
         crc_before_ff <= crc_before_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      store_ff   <= store_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_msg_type    = rsp_ff.msg_type;
   assign rsp_payload     = rsp_ff.payload;
   assign rsp_payload_len = rsp_ff.payload_len;

endmodule

`default_nettype wire

>>> rtl/scfd_checker.sv
// Port-level checks for the stuffed CRC-8 frame decoder, bound to the top level.
// Depends on scfd_pkg and stuffed_crc8_frame_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "stuffed_crc8_frame_decoder_macros.svh"

module scfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [7:0]  rsp_msg_type,
   input wire logic [55:0] rsp_payload,
   input wire logic [2:0]  rsp_payload_len
);

   `SCFD_ASSERT_RESET(a_rsp_idle_after_reset, clock, reset, !rsp_valid)

   `SCFD_ASSERT_SAME(a_fail_no_payload, clock, reset,
      rsp_valid && rsp_status != scfd_pkg::ST_OK,
      rsp_payload == 56'd0 && rsp_payload_len == 3'd0)

   `SCFD_ASSERT_SAME(a_ok_len_matches_type, clock, reset,
      rsp_valid && rsp_status == scfd_pkg::ST_OK,
      (rsp_msg_type == 8'd0 && rsp_payload_len == 3'd7) ||
      (rsp_msg_type == 8'd1 && rsp_payload_len == 3'd5) ||
      (rsp_msg_type > 8'd1 && rsp_msg_type < 8'd5 && rsp_payload_len == 3'd1))

   `SCFD_ASSERT_SAME(a_empty_no_type, clock, reset,
      rsp_valid && rsp_status == scfd_pkg::ST_EMPTY, rsp_msg_type == 8'd0)

   `SCFD_ASSERT_NEXT(a_stalled_rsp_holds, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_payload))

endmodule

bind stuffed_crc8_frame_decoder scfd_checker u_scfd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_msg_type    (rsp_msg_type),
   .rsp_payload     (rsp_payload),
   .rsp_payload_len (rsp_payload_len)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for stuffed_crc8_frame_decoder: byte-stuffed frames
// with CRC-8, predicted by a frame decoder model and checked per transaction.
// Depends on scfd_pkg and the stuffed_crc8_frame_decoder RTL.
`timescale 1ns / 1ps

module testbench;
   import scfd_pkg::*;

   localparam int MAX_FRAME = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT = 8;
   localparam int HOLD_CYCLES = 400;
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam int FRAME_LEN [5] = '{9, 7, 3, 3, 3};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_msg_type;
   logic [55:0] rsp_payload;
   logic [2:0]  rsp_payload_len;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_wdata = 8'h00;

   stuffed_crc8_frame_decoder #(.MAX_FRAME(MAX_FRAME)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_msg_type(rsp_msg_type), .rsp_payload(rsp_payload),
      .rsp_payload_len(rsp_payload_len),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder model state
   byte_type   crc_poly = POLY_RESET;
   byte_type   crc_seed = INIT_RESET;
   bit         framing = 1'b0;
   bit         escaping = 1'b0;
   int         frame_count = 0;
   byte_type   crc_now = INIT_RESET;
   byte_type   crc_prev = INIT_RESET;
   byte_type   last_seen = 8'h00;
   byte_type   frame_bytes [STORE_DEPTH];

   byte_type   byte_queue [$];
   result_type frames_due [$];
   int         items_accepted = 0;
   int         mismatches = 0;
   int         cycle_count = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   logic       calm;

   assign calm = items_accepted >= 600 && items_accepted < 850;

   function automatic byte_type crc8_byte(input byte_type crc, input byte_type data,
                                          input byte_type poly);
      byte_type c;
      c = crc ^ data;
      repeat (8) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      return c;
   endfunction

   task automatic absorb_byte(input byte_type b);
      crc_prev = crc_now;
      crc_now = crc8_byte(crc_now, b, crc_poly);
      last_seen = b;
      if (frame_count < STORE_DEPTH) frame_bytes[frame_count] = b;
      if (frame_count < MAX_FRAME) frame_count++;
   endtask

   task automatic decode_byte(input byte_type b);
      result_type r;
      int n;
      if (!framing) begin
         if (b == FLAG_BYTE) begin
            framing = 1'b1;
            escaping = 1'b0;
            frame_count = 0;
            crc_now = crc_seed;
            crc_prev = crc_seed;
         end
      end else if (escaping) begin
         escaping = 1'b0;
         absorb_byte(b);
      end else if (b == ESC_BYTE) begin
         escaping = 1'b1;
      end else if (b == FLAG_BYTE) begin
         r = '0;
         if (frame_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.msg_type = frame_bytes[0];
            if (frame_bytes[0] >= 5) begin
               r.status = ST_UNKNOWN;
            end else if (frame_count != FRAME_LEN[frame_bytes[0]]) begin
               r.status = ST_BADLEN;
            end else if (crc_prev != last_seen) begin
               r.status = ST_BADCRC;
            end else begin
               r.status = ST_OK;
               n = frame_count - 2;
               for (int i = 0; i < n; i++) r.payload[8*i +: 8] = frame_bytes[i+1];
               r.payload_len = 3'(n);
            end
         end
         frames_due.push_back(r);
         framing = 1'b0;
         frame_count = 0;
      end else begin
         absorb_byte(b);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_rx_byte);
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_rx_byte <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= 300) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d type %02h payload %014h len %0d",
                        rsp_status, rsp_msg_type, rsp_payload, rsp_payload_len);
         end else begin
            want = frames_due.pop_front();
            if (rsp_status !== want.status || rsp_msg_type !== want.msg_type ||
                rsp_payload !== want.payload || rsp_payload_len !== want.payload_len) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected status %0d type %02h payload %014h len %0d",
                           want.status, want.msg_type, want.payload, want.payload_len);
                  $display("          actual   status %0d type %02h payload %014h len %0d",
                           rsp_status, rsp_msg_type, rsp_payload, rsp_payload_len);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || frames_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input byte_type data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_POLY) crc_poly = data;
      else if (idx == CSR_INIT) crc_seed = data;
   endtask

   function automatic byte_type pick_data();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic push_data(input byte_type b);
      if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0)
         byte_queue.push_back(ESC_BYTE);
      byte_queue.push_back(b);
   endtask

   // opening flag, type byte, body bytes, CRC over both (optionally spoilt), closing flag
   task automatic queue_frame(input byte_type mtype, input int body_len, input bit spoil);
      byte_type crc;
      byte_type b;
      crc = crc8_byte(crc_seed, mtype, crc_poly);
      byte_queue.push_back(FLAG_BYTE);
      push_data(mtype);
      for (int i = 0; i < body_len; i++) begin
         b = pick_data();
         crc = crc8_byte(crc, b, crc_poly);
         push_data(b);
      end
      if (spoil) crc ^= byte_type'($urandom_range(1, 255));
      push_data(crc);
      byte_queue.push_back(FLAG_BYTE);
   endtask

   task automatic queue_traffic(input int target);
      int pick;
      int t;
      int n;
      while (byte_queue.size() < target) begin
         pick = $urandom_range(0, 99);
         t = $urandom_range(0, 4);
         if (pick < 60) begin
            queue_frame(byte_type'(t), FRAME_LEN[t] - 2, 1'b0);
         end else if (pick < 70) begin
            queue_frame(byte_type'(t), FRAME_LEN[t] - 2, 1'b1);
         end else if (pick < 78) begin
            do n = $urandom_range(1, 10);
            while (n == FRAME_LEN[t]);
            byte_queue.push_back(FLAG_BYTE);
            push_data(byte_type'(t));
            repeat (n - 1) push_data(pick_data());
            byte_queue.push_back(FLAG_BYTE);
         end else if (pick < 84) begin
            queue_frame(byte_type'($urandom_range(5, 255)), $urandom_range(0, 8), 1'b0);
         end else if (pick < 88) begin
            byte_queue.push_back(FLAG_BYTE);
            byte_queue.push_back(FLAG_BYTE);
         end else if (pick < 91) begin
            queue_frame(byte_type'(t), $urandom_range(31, 38), 1'b0);
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 3) == 0) byte_queue.push_back(ESC_BYTE);
               else byte_queue.push_back(byte_type'($urandom_range(0, 8'h7d)));
            end
         end else begin
            // escape swallows what was meant as the closing flag
            byte_queue.push_back(FLAG_BYTE);
            repeat ($urandom_range(0, 3)) push_data(pick_data());
            byte_queue.push_back(ESC_BYTE);
         end
      end
   endtask

   initial begin
      byte_type crc;
      byte_type polys [5];
      byte_type seeds [5];
      polys = '{8'hff, 8'h00, byte_type'($urandom_range(0, 255)), POLY_RESET,
                byte_type'($urandom_range(0, 255))};
      seeds = '{8'hff, 8'h00, byte_type'($urandom_range(0, 255)), INIT_RESET,
                byte_type'($urandom_range(0, 255))};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // escape outside a frame is dropped, then an empty frame
      byte_queue.push_back(ESC_BYTE);
      byte_queue.push_back(FLAG_BYTE);
      byte_queue.push_back(FLAG_BYTE);
      // ok frame carrying an escaped flag byte
      crc = crc8_byte(crc8_byte(crc_seed, 8'h02, crc_poly), FLAG_BYTE, crc_poly);
      byte_queue.push_back(FLAG_BYTE);
      byte_queue.push_back(8'h02);
      byte_queue.push_back(ESC_BYTE);
      byte_queue.push_back(FLAG_BYTE);
      push_data(crc);
      byte_queue.push_back(FLAG_BYTE);
      // unknown type at the top of the range
      byte_queue.push_back(FLAG_BYTE);
      byte_queue.push_back(8'hff);
      byte_queue.push_back(FLAG_BYTE);
      // too short for its type
      byte_queue.push_back(FLAG_BYTE);
      byte_queue.push_back(8'h01);
      byte_queue.push_back(8'h00);
      byte_queue.push_back(FLAG_BYTE);
      // escaped escape as payload, wrong crc
      byte_queue.push_back(FLAG_BYTE);
      byte_queue.push_back(8'h04);
      byte_queue.push_back(ESC_BYTE);
      byte_queue.push_back(ESC_BYTE);
      push_data(crc8_byte(crc8_byte(crc_seed, 8'h04, crc_poly), ESC_BYTE, crc_poly) ^ 8'h01);
      byte_queue.push_back(FLAG_BYTE);
      // register writes in the middle of a frame
      byte_queue.push_back(FLAG_BYTE);
      byte_queue.push_back(8'h03);
      crc = crc8_byte(crc_seed, 8'h03, crc_poly);
      wait_idle();
      write_csr(CSR_POLY, 8'h1d);
      write_csr(CSR_INIT, 8'hff);
      crc = crc8_byte(crc, 8'h00, crc_poly);
      byte_queue.push_back(8'h00);
      push_data(crc);
      byte_queue.push_back(FLAG_BYTE);
      // new initial value takes effect from this open
      queue_frame(8'h04, 1, 1'b0);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_POLY, polys[p]);
         write_csr(CSR_INIT, seeds[p]);
         if (p == 2) begin
            write_csr(CSR_SPARE_A, byte_type'($urandom_range(0, 255)));
            write_csr(CSR_SPARE_B, byte_type'($urandom_range(0, 255)));
         end
         queue_traffic(210);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> stuffed_crc8_frame_decoder.f
+incdir+rtl
rtl/scfd_pkg.sv
rtl/scfd_classify.sv
rtl/stuffed_crc8_frame_decoder.sv
rtl/scfd_checker.sv
tb/testbench.sv
